// ----- design/xcr_pkg.sv -----
// Shared constants and the CRC-16 byte update for the XMODEM-CRC receiver.
// No dependencies; imported by the receiver top level.
package xcr_pkg;

   // Default packet payload size in bytes (multiple of 4).
   localparam int BLOCK_BYTES_DEFAULT = 128;

   // Protocol characters.
   localparam logic [7:0] CH_C   = 8'h43;
   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_CAN = 8'h18;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   // Result kinds.
   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_REPLY  = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   // Receive phases.
   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_PACKET = 2'd1;
   localparam logic [1:0] PH_DONE   = 2'd2;

   // Feed one byte into the CRC-16, MSB first.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ----- design/xmodem_crc_receiver_top.sv -----
// XMODEM-CRC receiver top level: packet parser, CRC check and word writer.
// Depends on xcr_pkg and on xcr_ram for the packet buffer.
//
// Usage:
//  - req channel: one request is a received UART byte (req_tuser = 0) or a
//    poll timeout tick (req_tuser = 1). req_tready is high while the block
//    is idle.
//  - rsp channel: memory word writes, reply bytes (C, ACK, NAK, CAN) and a
//    final finish report; rsp_tlast marks the last result of a request.
//  - csr channel: writes the base address; always ready, write only while idle.
//  - Sequencing: a reply or finish result is loaded into the output register
//    from the REPLY or FINISH state once the output is free. After the last
//    CRC byte of a good packet, the buffer is read back word by word (RAM read,
//    then output load), and the ACK is loaded after the last word.
//  - Data bytes are packed into words as they arrive and written to the
//    buffer RAM every fourth byte; the drain is limited by its one read port.
//  - A stalled rsp_tready holds the output register and the sequencer; the
//    block takes a new request only after all results of the previous one
//    have been loaded, and may take it while the last one still waits.
//  - Reset clears all control state; the buffer RAM is not cleared, since a
//    packet fills every entry before any is read.
module xmodem_crc_receiver_top
   import xcr_pkg::*;
#(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] rx_byte
   input  logic         req_tuser,   // [0] opcode
   // Result channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] write_address, [63:32] write_word, [71:64] reply_byte,
   // [72] transfer_ok, [104:73] received_size, [111:105] zero
   output logic [111:0] rsp_tdata,
   output logic [1:0]   rsp_tuser,   // [1:0] kind
   output logic         rsp_tlast,   // last
   // Configuration channel.
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_wdata    // base_address
);

   localparam int WORDS = BLOCK_BYTES / 4;
   localparam int WA_W  = $clog2(WORDS);
   localparam int BI_W  = $clog2(BLOCK_BYTES + 5);
   localparam logic [BI_W-1:0] IDX_NUMBER = BI_W'(0);
   localparam logic [BI_W-1:0] IDX_COMPL  = BI_W'(1);
   localparam logic [BI_W-1:0] IDX_DATA0  = BI_W'(2);
   localparam logic [BI_W-1:0] IDX_DATAE  = BI_W'(BLOCK_BYTES + 2);
   localparam logic [BI_W-1:0] IDX_LAST   = BI_W'(BLOCK_BYTES + 3);
   localparam logic [WA_W-1:0] WORD_LAST  = WA_W'(WORDS - 1);
   localparam logic [31:0]     BLOCK_SIZE = 32'(BLOCK_BYTES);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REPLY  = 3'd1;
   localparam logic [2:0] ST_FINISH = 3'd2;
   localparam logic [2:0] ST_READ   = 3'd3;
   localparam logic [2:0] ST_WORD   = 3'd4;

   logic [2:0]      state_ff, state_in;
   logic [1:0]      phase_ff, phase_in;
   logic            header_seen_ff, header_seen_in;
   logic [BI_W-1:0] idx_ff, idx_in;
   logic [7:0]      expected_ff, expected_in;
   logic [7:0]      number_ff, number_in;
   logic [7:0]      complement_ff, complement_in;
   logic [15:0]     crc_ff, crc_in;
   logic [31:0]     stored_ff, stored_in;
   logic [31:0]     base_ff, base_in;
   logic [23:0]     asm_ff, asm_in;
   logic [7:0]      reply_ff, reply_in;
   logic            then_finish_ff, then_finish_in;
   logic            finish_ok_ff, finish_ok_in;
   logic [WA_W-1:0] word_ff, word_in;
   logic [31:0]     addr_ff, addr_in;

   // Output register.
   logic            rsp_valid_ff, rsp_valid_in;
   logic [1:0]      kind_ff, kind_in;
   logic [31:0]     waddr_ff, waddr_in;
   logic [31:0]     wword_ff, wword_in;
   logic [7:0]      rbyte_ff, rbyte_in;
   logic            ok_ff, ok_in;
   logic [31:0]     size_ff, size_in;
   logic            last_ff, last_in;

   // Buffer RAM ports.
   logic            ram_wr_en;
   logic [WA_W-1:0] ram_wr_addr;
   logic [31:0]     ram_wr_data;
   logic            ram_rd_en;
   logic [31:0]     ram_rd_data;

   logic            accept;
   logic            out_free;
   logic            out_load;
   logic [7:0]      rx;
   logic [15:0]     crc_next;
   logic [BI_W-1:0] data_idx;
   logic            good_packet;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rx         = req_tdata;
   assign crc_next   = crc_feed(crc_ff, rx);
   assign data_idx   = idx_ff - IDX_DATA0;
   assign csr_ready  = 1'b1;

   // Packet is good when the number matches, the complement checks and CRC is zero.
   assign good_packet = (number_ff == expected_ff) && (complement_ff == ~number_ff)
                        && (crc_next == 16'h0000);

   xcr_ram #(
      .WIDTH(32),
      .DEPTH(WORDS)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (word_ff),
      .rd_data (ram_rd_data)
   );

   // Request parsing and result sequencing.
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      header_seen_in = header_seen_ff;
      idx_in         = idx_ff;
      expected_in    = expected_ff;
      number_in      = number_ff;
      complement_in  = complement_ff;
      crc_in         = crc_ff;
      stored_in      = stored_ff;
      base_in        = base_ff;
      asm_in         = asm_ff;
      reply_in       = reply_ff;
      then_finish_in = then_finish_ff;
      finish_ok_in   = finish_ok_ff;
      word_in        = word_ff;
      addr_in        = addr_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = data_idx[WA_W+1:2];
      ram_wr_data    = {rx, asm_ff};
      ram_rd_en      = 1'b0;
      out_load       = 1'b0;
      kind_in        = kind_ff;
      waddr_in       = waddr_ff;
      wword_in       = wword_ff;
      rbyte_in       = rbyte_ff;
      ok_in          = ok_ff;
      size_in        = size_ff;
      last_in        = last_ff;

      if (csr_valid) begin
         base_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (phase_ff != PH_DONE)) begin
               if (req_tuser) begin
                  // Poll tick: invite a CRC transfer until the first byte.
                  if (!header_seen_ff) begin
                     reply_in       = CH_C;
                     then_finish_in = 1'b0;
                     state_in       = ST_REPLY;
                  end
               end else if (phase_ff == PH_HEADER) begin
                  header_seen_in = 1'b1;
                  if (rx == CH_SOH) begin
                     phase_in = PH_PACKET;
                     idx_in   = IDX_NUMBER;
                     crc_in   = 16'h0000;
                  end else if (rx == CH_EOT) begin
                     reply_in       = CH_ACK;
                     then_finish_in = 1'b1;
                     finish_ok_in   = 1'b1;
                     phase_in       = PH_DONE;
                     state_in       = ST_REPLY;
                  end else begin
                     finish_ok_in = 1'b0;
                     phase_in     = PH_DONE;
                     state_in     = ST_FINISH;
                  end
               end else begin
                  // Packet body byte.
                  if (idx_ff == IDX_NUMBER) begin
                     number_in = rx;
                  end else if (idx_ff == IDX_COMPL) begin
                     complement_in = rx;
                  end else begin
                     crc_in = crc_next;
                     if (idx_ff < IDX_DATAE) begin
                        asm_in = {rx, asm_ff[23:8]};
                        if (data_idx[1:0] == 2'd3) begin
                           ram_wr_en = 1'b1;
                        end
                     end
                  end
                  idx_in = idx_ff + BI_W'(1);
                  if (idx_ff == IDX_LAST) begin
                     idx_in         = IDX_NUMBER;
                     phase_in       = PH_HEADER;
                     then_finish_in = 1'b0;
                     if (good_packet) begin
                        addr_in  = base_ff + stored_ff;
                        word_in  = '0;
                        state_in = ST_READ;
                     end else if (number_ff == expected_ff) begin
                        reply_in = CH_NAK;
                        state_in = ST_REPLY;
                     end else if (number_ff == expected_ff - 8'd1) begin
                        reply_in = CH_ACK;
                        state_in = ST_REPLY;
                     end else begin
                        reply_in = CH_CAN;
                        state_in = ST_REPLY;
                     end
                  end
               end
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               out_load = 1'b1;
               kind_in  = KIND_REPLY;
               waddr_in = 32'h0;
               wword_in = 32'h0;
               rbyte_in = reply_ff;
               ok_in    = 1'b0;
               size_in  = 32'h0;
               last_in  = !then_finish_ff;
               state_in = then_finish_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_load = 1'b1;
               kind_in  = KIND_FINISH;
               waddr_in = 32'h0;
               wword_in = 32'h0;
               rbyte_in = 8'h00;
               ok_in    = finish_ok_ff;
               size_in  = stored_ff;
               last_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_WORD;
         end
         ST_WORD: begin
            if (out_free) begin
               out_load = 1'b1;
               kind_in  = KIND_WRITE;
               waddr_in = addr_ff;
               wword_in = ram_rd_data;
               rbyte_in = 8'h00;
               ok_in    = 1'b0;
               size_in  = 32'h0;
               last_in  = 1'b0;
               addr_in  = addr_ff + 32'd4;
               word_in  = word_ff + WA_W'(1);
               if (word_ff == WORD_LAST) begin
                  // Whole packet written: commit it and acknowledge.
                  stored_in   = stored_ff + BLOCK_SIZE;
                  expected_in = expected_ff + 8'd1;
                  reply_in    = CH_ACK;
                  state_in    = ST_REPLY;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Output valid: set on load, cleared when taken.
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_ff       <= PH_HEADER;
         header_seen_ff <= 1'b0;
         idx_ff         <= '0;
         expected_ff    <= 8'd1;
         number_ff      <= 8'h00;
         complement_ff  <= 8'h00;
         crc_ff         <= 16'h0000;
         stored_ff      <= 32'h0;
         base_ff        <= 32'h0;
         then_finish_ff <= 1'b0;
         finish_ok_ff   <= 1'b0;
         word_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         header_seen_ff <= header_seen_in;
         idx_ff         <= idx_in;
         expected_ff    <= expected_in;
         number_ff      <= number_in;
         complement_ff  <= complement_in;
         crc_ff         <= crc_in;
         stored_ff      <= stored_in;
         base_ff        <= base_in;
         then_finish_ff <= then_finish_in;
         finish_ok_ff   <= finish_ok_in;
         word_ff        <= word_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      asm_ff   <= asm_in;
      reply_ff <= reply_in;
      addr_ff  <= addr_in;
      kind_ff  <= kind_in;
      waddr_ff <= waddr_in;
      wword_ff <= wword_in;
      rbyte_ff <= rbyte_in;
      ok_ff    <= ok_in;
      size_ff  <= size_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, size_ff, ok_ff, rbyte_ff, wword_ff, waddr_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ----- design/xcr_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module xcr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read; data holds while rd_en is low.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
